### src/erv_pkg.sv
// ----------------------------------------------------------------------------
// eight-register vm execute package
// shared constants, opcode, event and error codes, and the queue entry type
// ----------------------------------------------------------------------------
package erv_pkg;

	localparam int DATA_WIDTH  = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int NUM_REGS    = 8;
	localparam int REG_ADDR_W  = 3;

	localparam logic [2:0] OP_NOP   = 3'd0;
	localparam logic [2:0] OP_LOAD  = 3'd1;
	localparam logic [2:0] OP_MOVE  = 3'd2;
	localparam logic [2:0] OP_ADD   = 3'd3;
	localparam logic [2:0] OP_REM   = 3'd4;
	localparam logic [2:0] OP_JZ    = 3'd5;
	localparam logic [2:0] OP_PRINT = 3'd6;
	localparam logic [2:0] OP_PNUM  = 3'd7;

	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_CHAR = 2'd1;
	localparam logic [1:0] EV_STR  = 2'd2;
	localparam logic [1:0] EV_NUM  = 2'd3;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_REM_ZERO = 2'd1;
	localparam logic [1:0] ERR_STR_IDX  = 2'd2;

	localparam logic [9:0]  IMM_FLIP           = 10'h200;
	localparam logic [12:0] STR_OFFSET         = 13'd8;
	localparam logic [12:0] STRING_COUNT_RESET = 13'd3;

	typedef struct packed {
		logic [2:0]  op;
		logic [12:0] operand;
		logic        is_char;
		logic [12:0] str_idx;
		logic        str_ok;
	} entry_t;

endpackage

### src/erv_if.sv
// ----------------------------------------------------------------------------
// eight-register vm execute channels
// valid/ready channels for instructions, results and configuration
// ----------------------------------------------------------------------------
interface erv_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [12:0] operand;
	modport source (output valid, opcode, operand, input ready);
	modport sink (input valid, opcode, operand, output ready);
endinterface

interface erv_out_if;
	logic               valid;
	logic               ready;
	logic signed [9:0]  pc_step;
	logic [1:0]         event_kind;
	logic signed [31:0] event_value;
	logic [1:0]         error_code;
	logic signed [31:0] first_register;
	modport source (output valid, pc_step, event_kind, event_value, error_code,
		first_register, input ready);
	modport sink (input valid, pc_step, event_kind, event_value, error_code,
		first_register, output ready);
endinterface

interface erv_cfg_if;
	logic        valid;
	logic        ready;
	logic [12:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### src/erv_front.sv
// ----------------------------------------------------------------------------
// eight-register vm execute front end
// accepts instructions, holds the string count and classifies print operands
// ----------------------------------------------------------------------------
module erv_front (
	input  logic             clk,
	input  logic             arst_n,
	erv_in_if.sink           in_ch,
	erv_cfg_if.sink          cfg_ch,
	input  logic             q_full,
	output logic             push,
	output erv_pkg::entry_t  push_entry
);

	logic [12:0] string_count_q;
	logic [12:0] idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			string_count_q <= erv_pkg::STRING_COUNT_RESET;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			string_count_q <= cfg_ch.data;
		end
	end

	assign cfg_ch.ready = 1'b1;
	assign in_ch.ready  = !q_full;
	assign push         = in_ch.valid && !q_full;

	assign idx = in_ch.operand - erv_pkg::STR_OFFSET;

	always_comb begin
		push_entry.op      = in_ch.opcode;
		push_entry.operand = in_ch.operand;
		push_entry.is_char = (in_ch.operand[12:3] == 10'd0);
		push_entry.str_idx = idx;
		push_entry.str_ok  = (idx < string_count_q);
	end

endmodule

### src/erv_queue.sv
// ----------------------------------------------------------------------------
// eight-register vm execute queue
// short fifo of classified instructions between front and back
// ----------------------------------------------------------------------------
module erv_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  erv_pkg::entry_t  push_entry,
	output logic             full,
	input  logic             pop,
	output erv_pkg::entry_t  pop_entry,
	output logic             empty
);

	localparam int DEPTH = erv_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	erv_pkg::entry_t slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign pop_entry = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### src/erv_rem.sv
// ----------------------------------------------------------------------------
// eight-register vm execute remainder unit
// bit-serial restoring remainder on magnitudes, sign of the dividend
// ----------------------------------------------------------------------------
module erv_rem #(
	parameter int DATA_WIDTH = erv_pkg::DATA_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] result
);

	localparam int CNT_W = $clog2(DATA_WIDTH);

	logic                  busy_q;
	logic                  fin_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  neg_q;
	logic [DATA_WIDTH-1:0] dvd_q;
	logic [DATA_WIDTH-1:0] dvs_q;
	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] result_q;
	logic [DATA_WIDTH:0]   shifted;
	logic [DATA_WIDTH:0]   diff;
	logic [DATA_WIDTH-1:0] rem_next;

	assign shifted  = {rem_q, dvd_q[DATA_WIDTH-1]};
	assign diff     = shifted - {1'b0, dvs_q};
	assign rem_next = diff[DATA_WIDTH] ? shifted[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];

	// done holds until the next start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				done_q <= 1'b0;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DATA_WIDTH - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend[DATA_WIDTH-1] ? -dividend : dividend;
			dvs_q <= divisor[DATA_WIDTH-1] ? -divisor : divisor;
			neg_q <= dividend[DATA_WIDTH-1];
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DATA_WIDTH-2:0], 1'b0};
			rem_q <= rem_next;
		end else if (fin_q) begin
			result_q <= neg_q ? -rem_q : rem_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

### src/erv_back.sv
// ----------------------------------------------------------------------------
// eight-register vm execute back end
// register file, instruction execution and the result register
// ----------------------------------------------------------------------------
module erv_back #(
	parameter int DATA_WIDTH = erv_pkg::DATA_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  erv_pkg::entry_t       q_entry,
	output logic                  pop,
	erv_out_if.source             out_ch,
	output logic                  div_start,
	output logic [DATA_WIDTH-1:0] div_dividend,
	output logic [DATA_WIDTH-1:0] div_divisor,
	input  logic                  div_done,
	input  logic [DATA_WIDTH-1:0] div_result
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;

	localparam int NR = erv_pkg::NUM_REGS;
	localparam int AW = erv_pkg::REG_ADDR_W;

	logic [1:0] state_q;
	logic [1:0] state_d;

	logic signed [DATA_WIDTH-1:0] mem [NR];
	logic [NR-1:0]                valid_q;
	logic signed [DATA_WIDTH-1:0] rd_data_q;
	logic signed [DATA_WIDTH-1:0] rs_data_q;
	logic signed [DATA_WIDTH-1:0] reg0_q;
	erv_pkg::entry_t              entry_q;

	logic [AW-1:0]                rd_addr;
	logic [AW-1:0]                rs_addr;
	logic [AW-1:0]                q_rd_addr;
	logic [AW-1:0]                q_rs_addr;
	logic                         wr_en;
	logic signed [DATA_WIDTH-1:0] wr_data;
	logic signed [DATA_WIDTH-1:0] reg0_new;
	logic signed [9:0]            imm;
	logic                         slot_free;
	logic                         res_load;

	logic                         out_valid_q;
	logic signed [9:0]            res_step;
	logic [1:0]                   res_kind;
	logic signed [31:0]           res_value;
	logic [1:0]                   res_err;

	assign q_rd_addr = q_entry.operand[2:0];
	assign q_rs_addr = q_entry.operand[5:3];
	assign rd_addr   = entry_q.operand[2:0];
	assign rs_addr   = entry_q.operand[5:3];
	assign imm       = signed'(entry_q.operand[12:3] ^ erv_pkg::IMM_FLIP);
	assign slot_free = !out_valid_q || out_ch.ready;

	assign div_dividend = rd_data_q;
	assign div_divisor  = rs_data_q;

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		wr_en     = 1'b0;
		wr_data   = rd_data_q;
		div_start = 1'b0;
		res_load  = 1'b0;
		res_step  = 10'sd1;
		res_kind  = erv_pkg::EV_NONE;
		res_value = '0;
		res_err   = erv_pkg::ERR_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (slot_free) begin
					res_load = 1'b1;
					state_d  = ST_IDLE;
					unique case (entry_q.op)
						erv_pkg::OP_NOP: begin
						end
						erv_pkg::OP_LOAD: begin
							wr_en   = 1'b1;
							wr_data = DATA_WIDTH'(imm);
						end
						erv_pkg::OP_MOVE: begin
							wr_en   = 1'b1;
							wr_data = rs_data_q;
						end
						erv_pkg::OP_ADD: begin
							wr_en   = 1'b1;
							wr_data = rd_data_q + rs_data_q;
						end
						erv_pkg::OP_REM: begin
							if (rs_data_q == '0) begin
								res_err = erv_pkg::ERR_REM_ZERO;
							end else begin
								res_load  = 1'b0;
								div_start = 1'b1;
								state_d   = ST_DIV;
							end
						end
						erv_pkg::OP_JZ: begin
							if (rd_data_q == '0) begin
								res_step = imm;
							end
						end
						erv_pkg::OP_PRINT: begin
							if (entry_q.is_char) begin
								res_kind  = erv_pkg::EV_CHAR;
								res_value = {24'd0, rd_data_q[7:0]};
							end else begin
								res_value = {19'd0, entry_q.str_idx};
								if (entry_q.str_ok) begin
									res_kind = erv_pkg::EV_STR;
								end else begin
									res_err = erv_pkg::ERR_STR_IDX;
								end
							end
						end
						erv_pkg::OP_PNUM: begin
							res_kind  = erv_pkg::EV_NUM;
							res_value = 32'(rd_data_q);
						end
						default: begin
						end
					endcase
				end
			end
			ST_DIV: begin
				if (div_done && slot_free) begin
					wr_en    = 1'b1;
					wr_data  = signed'(div_result);
					res_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign reg0_new = (wr_en && rd_addr == '0) ? wr_data : reg0_q;

	// register file: unwritten entries read as zero
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[rd_addr] <= wr_data;
		end
		if (pop) begin
			rd_data_q <= valid_q[q_rd_addr] ? mem[q_rd_addr] : '0;
			rs_data_q <= valid_q[q_rs_addr] ? mem[q_rs_addr] : '0;
			entry_q   <= q_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			reg0_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			reg0_q  <= reg0_new;
			if (wr_en) begin
				valid_q[rd_addr] <= 1'b1;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_ch.pc_step        <= res_step;
			out_ch.event_kind     <= res_kind;
			out_ch.event_value    <= res_value;
			out_ch.error_code     <= res_err;
			out_ch.first_register <= 32'(reg0_new);
		end
	end

	assign out_ch.valid = out_valid_q;

endmodule

### src/eight_register_vm_execute_core.sv
// ----------------------------------------------------------------------------
// eight-register vm execute core
// executes one 16-bit instruction per item on eight signed registers
// ----------------------------------------------------------------------------
// Instructions enter through a two-entry queue, so the front keeps accepting
// while the back end works. The back end handles one instruction at a time:
// a queued instruction has a register read and an execute step, which waits
// while the result register is full, before its result is registered. A
// remainder with a non-zero divisor uses the bit-serial remainder unit, which
// retires one quotient bit per cycle. The register file resets to zero through
// per-entry valid bits, with no clearing pass. string_count may only be written
// while no instruction is in flight. first_register reports register zero.
module eight_register_vm_execute_core #(
	parameter int DATA_WIDTH = erv_pkg::DATA_WIDTH
) (
	input  logic       clk,
	input  logic       arst_n,
	erv_in_if.sink     in_ch,
	erv_out_if.source  out_ch,
	erv_cfg_if.sink    cfg_ch
);

	logic                  push;
	erv_pkg::entry_t       push_entry;
	logic                  q_full;
	logic                  pop;
	erv_pkg::entry_t       pop_entry;
	logic                  q_empty;
	logic                  div_start;
	logic [DATA_WIDTH-1:0] div_dividend;
	logic [DATA_WIDTH-1:0] div_divisor;
	logic                  div_done;
	logic [DATA_WIDTH-1:0] div_result;

	erv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.cfg_ch     (cfg_ch),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	erv_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.empty      (q_empty)
	);

	erv_rem #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.result   (div_result)
	);

	erv_back #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_entry      (pop_entry),
		.pop          (pop),
		.out_ch       (out_ch),
		.div_start    (div_start),
		.div_dividend (div_dividend),
		.div_divisor  (div_divisor),
		.div_done     (div_done),
		.div_result   (div_result)
	);

endmodule
